// ----- rtl/view_sector_test_defines.svh -----
// Assertion macros for the view sector test checker.
`ifndef VIEW_SECTOR_TEST_DEFINES_SVH
`define VIEW_SECTOR_TEST_DEFINES_SVH

// Check that cond always holds outside reset.
`define VST_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("vst check failed: cond");

// Check that ante implies cons outside reset.
`define VST_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vst check failed: implication");

`endif

// ----- rtl/vst_pkg.sv -----
// Shared types, constants and the arctangent table for the view sector test.
`default_nettype none
package vst_pkg;
   localparam int TABLE_LEN      = 24;
   localparam int EYE_OFFSET_DEF = 40;
   localparam int STAGES_DEF     = 16;
   localparam int GAIN_INV_Q16   = 39797;
   localparam int RW             = 32;   // rotation datapath width
   localparam int DW             = 27;   // offset vector width
   localparam int VW             = 38;   // vectoring datapath width
   localparam int AW             = 26;   // angle width in 1/32768 degree
   localparam int DEG            = 32768;
   localparam int FULL_OUT       = 46080;
   localparam int REQ_LAT_EXTRA  = 7;

   typedef struct packed {
      logic [15:0]        heading;
      logic signed [23:0] ox;
      logic signed [23:0] oz;
      logic signed [23:0] tx;
      logic signed [23:0] tz;
   } req_tag_type;

   function automatic int stage_count(input int n);
      return (n < TABLE_LEN) ? n : TABLE_LEN;
   endfunction

   function automatic logic signed [AW-1:0] atan_entry(input int i);
      logic signed [AW-1:0] r;
      case (i)
         0: r = AW'(1474560);
         1: r = AW'(870484);
         2: r = AW'(459940);
         3: r = AW'(233473);
         4: r = AW'(117189);
         5: r = AW'(58652);
         6: r = AW'(29333);
         7: r = AW'(14667);
         8: r = AW'(7334);
         9: r = AW'(3667);
         10: r = AW'(1833);
         11: r = AW'(917);
         12: r = AW'(458);
         13: r = AW'(229);
         14: r = AW'(115);
         15: r = AW'(57);
         16: r = AW'(29);
         17: r = AW'(14);
         18: r = AW'(7);
         19: r = AW'(4);
         20: r = AW'(2);
         21: r = AW'(1);
         default: r = '0;
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

// ----- rtl/vst_rot.sv -----
// Pipelined CORDIC rotation giving the eye offset times cos and sin of the heading.
`default_nettype none
module vst_rot #(
   parameter int STAGES     = vst_pkg::STAGES_DEF,
   parameter int EYE_OFFSET = vst_pkg::EYE_OFFSET_DEF,
   parameter int TAG_W      = 1
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   input  wire logic [15:0]                   in_heading,
   input  wire logic [TAG_W-1:0]              in_tag,
   output logic                               out_valid,
   output logic signed [vst_pkg::RW-1:0]      out_cos,
   output logic signed [vst_pkg::RW-1:0]      out_sin,
   output logic                               out_neg,
   output logic [TAG_W-1:0]                   out_tag
);
   localparam int N  = vst_pkg::stage_count(STAGES);
   localparam int RW = vst_pkg::RW;
   localparam int AW = vst_pkg::AW;
   localparam longint X0 = (longint'(EYE_OFFSET) * 256 * vst_pkg::GAIN_INV_Q16 + 32768) >>> 16;
   localparam logic signed [AW-1:0] A90  = AW'(90 * vst_pkg::DEG);
   localparam logic signed [AW-1:0] A180 = AW'(180 * vst_pkg::DEG);
   localparam logic signed [AW-1:0] A270 = AW'(270 * vst_pkg::DEG);
   localparam logic signed [AW-1:0] A360 = AW'(360 * vst_pkg::DEG);

   logic                 valid_ff [0:N];
   logic signed [RW-1:0] x_ff     [0:N];
   logic signed [RW-1:0] y_ff     [0:N];
   logic signed [AW-1:0] z_ff     [0:N];
   logic                 neg_ff   [0:N];
   logic [TAG_W-1:0]     tag_ff   [0:N];

   logic signed [AW-1:0] a_in;
   logic signed [AW-1:0] z_in;
   logic                 neg_in;

   always_comb begin
      a_in = signed'({2'b00, in_heading, 8'b0});
      if (a_in > A270) begin
         a_in = a_in - A360;
      end
      z_in   = a_in;
      neg_in = 1'b0;
      if (a_in > A90) begin
         z_in   = a_in - A180;
         neg_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
      x_ff[0]   <= RW'(X0);
      y_ff[0]   <= '0;
      z_ff[0]   <= z_in;
      neg_ff[0] <= neg_in;
      tag_ff[0] <= in_tag;
   end

   for (genvar i = 0; i < N; i++) begin : g_stage
      localparam logic signed [AW-1:0] ATAN = vst_pkg::atan_entry(i);
      logic signed [RW-1:0] x_in, y_in;
      logic signed [AW-1:0] zn_in;
      always_comb begin
         if (z_ff[i] >= 0) begin
            x_in  = x_ff[i] - (y_ff[i] >>> i);
            y_in  = y_ff[i] + (x_ff[i] >>> i);
            zn_in = z_ff[i] - ATAN;
         end else begin
            x_in  = x_ff[i] + (y_ff[i] >>> i);
            y_in  = y_ff[i] - (x_ff[i] >>> i);
            zn_in = z_ff[i] + ATAN;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else begin
            valid_ff[i+1] <= valid_ff[i];
         end
         x_ff[i+1]   <= x_in;
         y_ff[i+1]   <= y_in;
         z_ff[i+1]   <= zn_in;
         neg_ff[i+1] <= neg_ff[i];
         tag_ff[i+1] <= tag_ff[i];
      end
   end

   assign out_valid = valid_ff[N];
   assign out_cos   = x_ff[N];
   assign out_sin   = y_ff[N];
   assign out_neg   = neg_ff[N];
   assign out_tag   = tag_ff[N];
endmodule
`default_nettype wire

// ----- rtl/vst_vec.sv -----
// Pipelined CORDIC vectoring giving atan2 of the offset vector.
`default_nettype none
module vst_vec #(
   parameter int STAGES = vst_pkg::STAGES_DEF,
   parameter int TAG_W  = 1
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   input  wire logic signed [vst_pkg::DW-1:0] in_x,
   input  wire logic signed [vst_pkg::DW-1:0] in_y,
   input  wire logic [TAG_W-1:0]              in_tag,
   output logic                               out_valid,
   output logic signed [vst_pkg::AW-1:0]      out_angle,
   output logic [TAG_W-1:0]                   out_tag
);
   localparam int N  = vst_pkg::stage_count(STAGES);
   localparam int VW = vst_pkg::VW;
   localparam int AW = vst_pkg::AW;
   localparam logic signed [AW-1:0] A90 = AW'(90 * vst_pkg::DEG);

   logic                 valid_ff [0:N];
   logic signed [VW-1:0] x_ff     [0:N];
   logic signed [VW-1:0] y_ff     [0:N];
   logic signed [AW-1:0] z_ff     [0:N];
   logic                 zero_ff  [0:N];
   logic [TAG_W-1:0]     tag_ff   [0:N];

   logic signed [VW-1:0] sx, sy, x_in, y_in;
   logic signed [AW-1:0] z_in;

   always_comb begin
      sx = VW'(in_x) <<< 8;
      sy = VW'(in_y) <<< 8;
      x_in = sx;
      y_in = sy;
      z_in = '0;
      if (sx < 0) begin
         if (sy >= 0) begin
            x_in = sy;
            y_in = -sx;
            z_in = A90;
         end else begin
            x_in = -sy;
            y_in = sx;
            z_in = -A90;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
      x_ff[0]    <= x_in;
      y_ff[0]    <= y_in;
      z_ff[0]    <= z_in;
      zero_ff[0] <= (in_x == '0) && (in_y == '0);
      tag_ff[0]  <= in_tag;
   end

   for (genvar i = 0; i < N; i++) begin : g_stage
      localparam logic signed [AW-1:0] ATAN = vst_pkg::atan_entry(i);
      logic signed [VW-1:0] xn_in, yn_in;
      logic signed [AW-1:0] zn_in;
      always_comb begin
         if (y_ff[i] >= 0) begin
            xn_in = x_ff[i] + (y_ff[i] >>> i);
            yn_in = y_ff[i] - (x_ff[i] >>> i);
            zn_in = z_ff[i] + ATAN;
         end else begin
            xn_in = x_ff[i] - (y_ff[i] >>> i);
            yn_in = y_ff[i] + (x_ff[i] >>> i);
            zn_in = z_ff[i] - ATAN;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else begin
            valid_ff[i+1] <= valid_ff[i];
         end
         x_ff[i+1]    <= xn_in;
         y_ff[i+1]    <= yn_in;
         z_ff[i+1]    <= zn_in;
         zero_ff[i+1] <= zero_ff[i];
         tag_ff[i+1]  <= tag_ff[i];
      end
   end

   assign out_valid = valid_ff[N];
   assign out_angle = zero_ff[N] ? '0 : z_ff[N];
   assign out_tag   = tag_ff[N];
endmodule
`default_nettype wire

// ----- rtl/view_sector_test.sv -----
// Top level of the view sector test: a fully pipelined bearing and sector check.
// One beat is accepted every cycle (busy is low outside reset); its result is given
// as one rsp_valid strobe after the input register, the rotation chain, the offset
// register, the vectoring chain (each of at most 24 CORDIC stages) and the bearing,
// bound and output registers; the receiver cannot stall, so the pipeline never holds.
// The depth is set by the two unrolled CORDIC chains, rotation then vectoring.
// Write csr_data only while no beat is in flight.
`default_nettype none
module view_sector_test #(
   parameter int EYE_OFFSET    = vst_pkg::EYE_OFFSET_DEF,
   parameter int CORDIC_STAGES = vst_pkg::STAGES_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic signed [23:0] req_observer_x,
   input  wire logic signed [23:0] req_observer_z,
   input  wire logic [15:0]        req_observer_heading,
   input  wire logic signed [23:0] req_target_x,
   input  wire logic signed [23:0] req_target_z,
   output logic                    rsp_valid,
   output logic                    rsp_in_view,
   output logic [15:0]             rsp_target_bearing,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [7:0]         csr_data
);
   localparam int RW = vst_pkg::RW;
   localparam int DW = vst_pkg::DW;
   localparam int AW = vst_pkg::AW;
   localparam int TW = $bits(vst_pkg::req_tag_type);
   localparam logic signed [AW-1:0] B180 = AW'(180 * vst_pkg::DEG);
   localparam logic signed [AW-1:0] B360 = AW'(360 * vst_pkg::DEG);
   localparam logic [16:0] FULL17 = 17'(vst_pkg::FULL_OUT);
   localparam logic signed [17:0] FULLS = 18'(vst_pkg::FULL_OUT);

   logic [7:0] fov_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         fov_ff <= 8'd60;
      end else if (csr_valid && csr_ready) begin
         fov_ff <= csr_data;
      end
   end
   assign csr_ready = 1'b1;
   assign busy      = reset;

   // input register with heading reduction
   logic                 s1_valid_ff;
   vst_pkg::req_tag_type s1_tag_ff, s1_tag_in;
   always_comb begin
      s1_tag_in.heading = (req_observer_heading >= 16'(vst_pkg::FULL_OUT)) ?
         req_observer_heading - 16'(vst_pkg::FULL_OUT) : req_observer_heading;
      s1_tag_in.ox = req_observer_x;
      s1_tag_in.oz = req_observer_z;
      s1_tag_in.tx = req_target_x;
      s1_tag_in.tz = req_target_z;
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start && !busy;
      end
      s1_tag_ff <= s1_tag_in;
   end

   logic                 rot_valid, rot_neg;
   logic signed [RW-1:0] rot_cos, rot_sin;
   logic [TW-1:0]        rot_tag_bits;
   vst_pkg::req_tag_type rot_tag;

   vst_rot #(.STAGES(CORDIC_STAGES), .EYE_OFFSET(EYE_OFFSET), .TAG_W(TW)) u_rot (
      .clock(clock), .reset(reset),
      .in_valid(s1_valid_ff), .in_heading(s1_tag_ff.heading), .in_tag(s1_tag_ff),
      .out_valid(rot_valid), .out_cos(rot_cos), .out_sin(rot_sin),
      .out_neg(rot_neg), .out_tag(rot_tag_bits)
   );
   assign rot_tag = rot_tag_bits;

   // offset vector from eye point to target
   logic                 s2_valid_ff;
   logic signed [DW-1:0] s2_dx_ff, s2_dz_ff, s2_dx_in, s2_dz_in;
   logic [15:0]          s2_h_ff;
   logic signed [RW+1:0] c_n, s_n, dx_w, dz_w;
   always_comb begin
      c_n = rot_neg ? -(RW+2)'(rot_cos) : (RW+2)'(rot_cos);
      s_n = rot_neg ? -(RW+2)'(rot_sin) : (RW+2)'(rot_sin);
      dx_w = (RW+2)'(rot_tag.tx) - (RW+2)'(rot_tag.ox) - c_n;
      dz_w = (RW+2)'(rot_tag.tz) - (RW+2)'(rot_tag.oz) + s_n;
      s2_dx_in = dx_w[DW-1:0];
      s2_dz_in = dz_w[DW-1:0];
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= rot_valid;
      end
      s2_dx_ff <= s2_dx_in;
      s2_dz_ff <= s2_dz_in;
      s2_h_ff  <= rot_tag.heading;
   end

   logic                 vec_valid;
   logic signed [AW-1:0] vec_angle;
   logic [15:0]          vec_h;

   vst_vec #(.STAGES(CORDIC_STAGES), .TAG_W(16)) u_vec (
      .clock(clock), .reset(reset),
      .in_valid(s2_valid_ff), .in_x(s2_dx_ff), .in_y(s2_dz_ff), .in_tag(s2_h_ff),
      .out_valid(vec_valid), .out_angle(vec_angle), .out_tag(vec_h)
   );

   // bearing wrap
   logic                 s3_valid_ff;
   logic [23:0]          s3_b_ff;
   logic [15:0]          s3_h_ff;
   logic signed [AW-1:0] b_w;
   always_comb begin
      b_w = B180 - vec_angle;
      if (b_w < 0) begin
         b_w = b_w + B360;
      end else if (b_w >= B360) begin
         b_w = b_w - B360;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= vec_valid;
      end
      s3_b_ff <= b_w[23:0];
      s3_h_ff <= vec_h;
   end

   // round bearing, build sector bounds
   logic              s4_valid_ff;
   logic [15:0]       s4_ub_ff, s4_rmin_ff, s4_rmax_ff;
   logic [24:0]       b_r;
   logic [16:0]       ub_w;
   logic signed [17:0] v_w, rmin_w, rmax_w;
   always_comb begin
      b_r  = 25'(s3_b_ff) + 25'd128;
      ub_w = b_r[24:8];
      if (ub_w >= FULL17) begin
         ub_w = '0;
      end
      v_w    = signed'({3'b000, fov_ff, 7'b0});
      rmin_w = signed'({2'b00, s3_h_ff}) - v_w;
      if (rmin_w < 0) begin
         rmin_w = rmin_w + FULLS;
      end
      rmax_w = signed'({2'b00, s3_h_ff}) + v_w;
      if (rmax_w >= FULLS) begin
         rmax_w = rmax_w - FULLS;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
      s4_ub_ff   <= ub_w[15:0];
      s4_rmin_ff <= rmin_w[15:0];
      s4_rmax_ff <= rmax_w[15:0];
   end

   // sector compare and output register
   logic rsp_valid_ff, rsp_in_view_ff, in_view_in;
   logic [15:0] rsp_bearing_ff;
   always_comb begin
      if (s4_rmin_ff < s4_rmax_ff) begin
         in_view_in = (s4_rmin_ff < s4_ub_ff) && (s4_ub_ff < s4_rmax_ff);
      end else begin
         in_view_in = (s4_rmin_ff < s4_ub_ff) || (s4_ub_ff < s4_rmax_ff);
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s4_valid_ff;
      end
      rsp_in_view_ff <= in_view_in;
      rsp_bearing_ff <= s4_ub_ff;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_in_view        = rsp_in_view_ff;
   assign rsp_target_bearing = rsp_bearing_ff;
endmodule
`default_nettype wire

// ----- rtl/vst_checker.sv -----
// Port-level checker for the view sector test, bound to the top level.
`default_nettype none
`include "view_sector_test_defines.svh"
module vst_checker #(
   parameter int LAT = 2 * vst_pkg::STAGES_DEF + vst_pkg::REQ_LAT_EXTRA
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic [15:0] rsp_target_bearing
);
   `VST_ASSERT_ALWAYS(a_never_busy, clock, reset, !busy)
   `VST_ASSERT_IMPLY(a_bearing_range, clock, reset, rsp_valid, rsp_target_bearing < 16'd46080)
   `VST_ASSERT_IMPLY(a_beat_delivered, clock, reset, start && !busy, ##LAT rsp_valid)
   `VST_ASSERT_IMPLY(a_no_phantom, clock, reset, rsp_valid, $past(start && !busy, LAT))
endmodule

bind view_sector_test vst_checker #(
   .LAT(2 * vst_pkg::stage_count(CORDIC_STAGES) + vst_pkg::REQ_LAT_EXTRA)
) u_vst_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_target_bearing(rsp_target_bearing)
);
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the view sector test: a bearing predictor and a scoreboard.
module testbench;
   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic signed [23:0] req_observer_x = '0;
   logic signed [23:0] req_observer_z = '0;
   logic [15:0]        req_observer_heading = '0;
   logic signed [23:0] req_target_x = '0;
   logic signed [23:0] req_target_z = '0;
   logic               rsp_valid;
   logic               rsp_in_view;
   logic [15:0]        rsp_target_bearing;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [7:0]         csr_data = '0;

   localparam int LAT_WAIT = 2 * vst_pkg::STAGES_DEF + vst_pkg::REQ_LAT_EXTRA + 10;
   localparam int CYCLE_LIMIT = 400000;

   view_sector_test dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_observer_x(req_observer_x), .req_observer_z(req_observer_z),
      .req_observer_heading(req_observer_heading),
      .req_target_x(req_target_x), .req_target_z(req_target_z),
      .rsp_valid(rsp_valid), .rsp_in_view(rsp_in_view),
      .rsp_target_bearing(rsp_target_bearing),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   typedef struct {
      logic        in_view;
      logic [15:0] bearing;
   } sight_type;

   class sight_board;
      sight_type   pending[$];
      logic [7:0]  half_fov;
      int          errors;
      longint      atan_lut[24];

      function new();
         half_fov = 8'd60;
         errors = 0;
         atan_lut = '{1474560, 870484, 459940, 233473, 117189, 58652, 29333, 14667,
                      7334, 3667, 1833, 917, 458, 229, 115, 57,
                      29, 14, 7, 4, 2, 1, 0, 0};
      endfunction

      function void eye_shift(input longint a, output longint c, output longint s);
         longint x, y, z, nx;
         bit     neg;
         x = (longint'(vst_pkg::EYE_OFFSET_DEF) * 256 * vst_pkg::GAIN_INV_Q16 + 32768) >>> 16;
         y = 0;
         z = a;
         neg = 0;
         if (z > 270 * vst_pkg::DEG) z -= 360 * vst_pkg::DEG;
         if (z > 90 * vst_pkg::DEG) begin
            z -= 180 * vst_pkg::DEG;
            neg = 1;
         end
         for (int i = 0; i < vst_pkg::STAGES_DEF; i++) begin
            if (z >= 0) begin
               nx = x - (y >>> i); y = y + (x >>> i); z -= atan_lut[i];
            end else begin
               nx = x + (y >>> i); y = y - (x >>> i); z += atan_lut[i];
            end
            x = nx;
         end
         c = neg ? -x : x;
         s = neg ? -y : y;
      endfunction

      function longint offset_angle(input longint vx, input longint vy);
         longint x, y, z, t, nx;
         if (vx == 0 && vy == 0) return 0;
         x = vx * 256;
         y = vy * 256;
         z = 0;
         if (x < 0) begin
            if (y >= 0) begin
               t = x; x = y; y = -t; z = 90 * vst_pkg::DEG;
            end else begin
               t = x; x = -y; y = t; z = -90 * vst_pkg::DEG;
            end
         end
         for (int i = 0; i < vst_pkg::STAGES_DEF; i++) begin
            if (y >= 0) begin
               nx = x + (y >>> i); y = y - (x >>> i); z += atan_lut[i];
            end else begin
               nx = x - (y >>> i); y = y + (x >>> i); z -= atan_lut[i];
            end
            x = nx;
         end
         return z;
      endfunction

      function void note_beat(input logic signed [23:0] ox, input logic signed [23:0] oz,
                              input logic [15:0] hd, input logic signed [23:0] tx,
                              input logic signed [23:0] tz);
         longint    h, c, s, b, ub, v, lo, hi;
         sight_type e;
         h = hd;
         if (h >= vst_pkg::FULL_OUT) h -= vst_pkg::FULL_OUT;
         eye_shift(h * 256, c, s);
         b = 180 * vst_pkg::DEG - offset_angle(longint'(tx) - (longint'(ox) + c),
                                               longint'(tz) - (longint'(oz) - s));
         if (b < 0) b += 360 * vst_pkg::DEG;
         if (b >= 360 * vst_pkg::DEG) b -= 360 * vst_pkg::DEG;
         ub = (b + 128) >>> 8;
         if (ub >= vst_pkg::FULL_OUT) ub -= vst_pkg::FULL_OUT;
         v = longint'(half_fov) * 128;
         lo = h - v;
         if (lo < 0) lo += vst_pkg::FULL_OUT;
         hi = h + v;
         if (hi >= vst_pkg::FULL_OUT) hi -= vst_pkg::FULL_OUT;
         if (lo < hi) e.in_view = (lo < ub) && (ub < hi);
         else         e.in_view = (lo < ub) || (ub < hi);
         e.bearing = ub[15:0];
         pending.push_back(e);
      endfunction

      function void check_result(input logic iv, input logic [15:0] br);
         sight_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result in_view=%0b bearing=%0d", $time, iv, br);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (iv !== e.in_view) begin
            $display("%0t: in_view expected %0b actual %0b", $time, e.in_view, iv);
            errors++;
         end
         if (br !== e.bearing) begin
            $display("%0t: target_bearing expected %0d actual %0d", $time, e.bearing, br);
            errors++;
         end
      endfunction
   endclass

   sight_board board = new();
   int cycles = 0;
   bit tail = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            board.note_beat(req_observer_x, req_observer_z, req_observer_heading,
                            req_target_x, req_target_z);
         if (rsp_valid)
            board.check_result(rsp_in_view, rsp_target_bearing);
         if (csr_valid && csr_ready)
            board.half_fov = csr_data;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("** view_sector_test: FAILED **");
         $finish;
      end
   end

   task automatic send_beat(input logic signed [23:0] ox, input logic signed [23:0] oz,
                            input logic [15:0] hd, input logic signed [23:0] tx,
                            input logic signed [23:0] tz);
      bit ok;
      start <= 1'b1;
      req_observer_x <= ox;
      req_observer_z <= oz;
      req_observer_heading <= hd;
      req_target_x <= tx;
      req_target_z <= tz;
      do begin
         @(negedge clock);
         ok = !busy;
         @(posedge clock);
      end while (!ok);
   endtask

   task automatic hold_off(input int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LAT_WAIT) @(posedge clock);
   endtask

   task automatic write_fov(input logic [7:0] val);
      bit ok;
      drain();
      csr_valid <= 1'b1;
      csr_data <= val;
      do begin
         @(negedge clock);
         ok = csr_ready;
         @(posedge clock);
      end while (!ok);
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [23:0] pick_coord();
      case ($urandom_range(0, 3))
         0: return 24'($urandom);
         1: return $urandom_range(0, 1) ? 24'sh7FFFFF : -24'sh800000;
         default: return 24'($signed($urandom_range(0, 8191)) - 4096);
      endcase
   endfunction

   task automatic random_beat();
      logic signed [23:0] ox, oz, tx, tz;
      logic [15:0]        hd;
      ox = pick_coord();
      oz = pick_coord();
      hd = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
           16'($urandom_range(0, vst_pkg::FULL_OUT - 1));
      if ($urandom_range(0, 2) != 0) begin
         tx = ox + 24'($signed($urandom_range(0, 65535)) - 32768);
         tz = oz + 24'($signed($urandom_range(0, 65535)) - 32768);
      end else begin
         tx = pick_coord();
         tz = pick_coord();
      end
      send_beat(ox, oz, hd, tx, tz);
      if (!tail && $urandom_range(0, 5) == 0) hold_off($urandom_range(1, 7));
   endtask

   task automatic directed_beats();
      longint c, s;
      logic [15:0] hd[8];
      hd = '{16'd0, 16'd11520, 16'd11521, 16'd23040, 16'd34560, 16'd46079,
             16'd46080, 16'hFFFF};
      foreach (hd[i]) send_beat(24'sd0, 24'sd0, hd[i], 24'sd25600, 24'sd0);
      send_beat(24'sh7FFFFF, 24'sh7FFFFF, 16'd100, -24'sh800000, -24'sh800000);
      send_beat(-24'sh800000, -24'sh800000, 16'd30000, 24'sh7FFFFF, 24'sh7FFFFF);
      send_beat(-24'sh800000, 24'sh7FFFFF, 16'd5000, 24'sh7FFFFF, -24'sh800000);
      board.eye_shift(0, c, s);
      send_beat(24'sd0, 24'sd0, 16'd0, 24'(c), 24'(-s));
      board.eye_shift(longint'(17000) * 256, c, s);
      send_beat(24'sd1000, -24'sd1000, 16'd17000, 24'(1000 + c), 24'(-1000 - s));
      send_beat(24'sd0, 24'sd0, 16'd0, -24'sd5000, 24'sd3);
      send_beat(24'sd0, 24'sd0, 16'd0, -24'sd5000, -24'sd3);
      send_beat(24'sd0, 24'sd0, 16'd7680, 24'sd0, 24'sd9000);
      send_beat(24'sd0, 24'sd0, 16'd38400, 24'sd0, -24'sd9000);
      hold_off(1);
   endtask

   initial begin
      logic [7:0] fovs[7];
      fovs = '{8'd1, 8'd179, 8'd0, 8'd255, 8'd90, 8'd180, 8'd60};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_beats();
      repeat (110) random_beat();
      drain();
      repeat (10) random_beat();
      foreach (fovs[p]) begin
         write_fov(fovs[p]);
         repeat (100) random_beat();
         write_fov(8'($urandom));
         repeat (10) random_beat();
      end
      tail = 1;
      repeat (40) random_beat();
      drain();
      if (board.errors == 0)
         $display("** view_sector_test: PASSED **");
      else
         $display("** view_sector_test: FAILED **");
      $finish;
   end
endmodule
